### rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg: shared types and constants for the raycast wall slice block
// Widths of the ray and slice fields, register reset values, register indexes.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int SCREEN_SIZE_DEF = 1024;

  localparam int POS_W  = 24;
  localparam int DIR_W  = 18;
  localparam int DIST_W = 24;
  localparam int VS_W   = 19;
  localparam int TEXW_W = 11;
  localparam int TEX_W  = 10;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [VS_W-1:0]   VS_RESET  = '0;
  localparam logic [TEXW_W-1:0] TEXW_RESET = 11'd64;

  typedef enum logic [0:0] {
    CFG_VSHIFT    = 1'b0,
    CFG_TEX_WIDTH = 1'b1
  } cfg_idx_t;

endpackage

### rtl/rws_div.sv
// ----------------------------------------------------------------------------
// rws_div: pipelined restoring divider
// One quotient bit per stage, QW stages. The caller guarantees num < den<<QW.
// ----------------------------------------------------------------------------
module rws_div #(
  parameter int NW = 41,
  parameter int DW = 18,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  logic [DW-1:0] src_rem [QW];
  logic [QW-1:0] src_low [QW];
  logic [DW-1:0] src_den [QW];
  logic [QW-1:0] src_quo [QW];
  logic [DW:0]   shf     [QW];
  logic [DW:0]   diff    [QW];

  // select stage inputs and trial-subtract the divisor
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        src_rem[k] = DW'(num >> QW);
        src_low[k] = num[QW-1:0];
        src_den[k] = den;
        src_quo[k] = '0;
      end else begin
        src_rem[k] = rem_r[k-1];
        src_low[k] = low_r[k-1];
        src_den[k] = den_r[k-1];
        src_quo[k] = quo_r[k-1];
      end
      shf[k]  = {src_rem[k], src_low[k][QW-1]};
      diff[k] = shf[k] - {1'b0, src_den[k]};
    end
  end

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= diff[k][DW] ? shf[k][DW-1:0] : diff[k][DW-1:0];
        low_r[k] <= src_low[k] << 1;
        den_r[k] <= src_den[k];
        quo_r[k] <= {src_quo[k][QW-2:0], ~diff[k][DW]};
      end
    end
  end

  assign quo = quo_r[QW-1];
  assign rem = rem_r[QW-1];

endmodule

### rtl/rws_dly.sv
// ----------------------------------------------------------------------------
// rws_dly: enabled delay line
// Carries side data alongside the divider stages so it lines up with results.
// ----------------------------------------------------------------------------
module rws_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

### rtl/raycast_wall_slice.sv
// ----------------------------------------------------------------------------
// raycast_wall_slice: wall column projection for a raycaster
// The bit-per-stage row offset divider runs after the distance divider.
// Throughput is one ray per cycle; the whole pipe stalls only when the
// output holds a result that is not taken. Synchronous active-low reset
// clears valid bits and sets vertical_shift to 0 and texture_width to 64.
// ----------------------------------------------------------------------------
module raycast_wall_slice #(
  parameter int SCREEN_SIZE = rws_pkg::SCREEN_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // map_x, map_y, pos_x, pos_y, dir_x, dir_y, step_x_neg, step_y_neg, pad
  input  logic [103:0] in_tdata,
  // side
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // perp_dist, slice height, top row, bottom row, tex_col, pad
  output logic [87:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [0:0]   cfg_index,
  input  logic [18:0]  cfg_wr_data
);

  localparam int C   = SCREEN_SIZE / 2;
  localparam int TW  = $clog2(C + 1) + 18;
  localparam int SW  = $clog2(SCREEN_SIZE + 1);
  localparam int VW  = TW + 3;
  localparam int L   = TW + 27;
  localparam int DW  = rws_pkg::DIST_W;

  logic en;
  logic [L-1:0] vld_r;

  // configuration registers
  logic signed [18:0] vs_r;
  logic [10:0]        texw_r;
  logic [TW-1:0]      tabs_r;
  logic               tneg_r;
  logic [18:0]        vs_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r   <= rws_pkg::VS_RESET;
      texw_r <= rws_pkg::TEXW_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == rws_pkg::CFG_VSHIFT) begin
        vs_r <= cfg_wr_data;
      end else begin
        texw_r <= cfg_wr_data[10:0];
      end
    end
  end

  // row offset numerator |C*vs| and its sign
  assign vs_abs = vs_r[18] ? 19'(-vs_r) : vs_r;
  always_ff @(posedge clk) begin
    tabs_r <= TW'(vs_abs) * TW'(C);
    tneg_r <= vs_r[18];
  end

  // global advance and valid pipe
  assign en        = !vld_r[L-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end

  // input stage: pick axis, form |edge - pos| and |dir|
  logic              xside;
  logic [7:0]        wall_idx;
  logic [23:0]       pos, pos_o;
  logic signed [17:0] dir, dir_o, dir_x, dir_y;
  logic              neg;
  logic signed [25:0] num_s;
  logic [24:0]       anum;
  logic [17:0]       adir;

  assign dir_x    = in_tdata[81:64];
  assign dir_y    = in_tdata[99:82];
  assign xside    = ~in_tuser[1];
  assign wall_idx = xside ? in_tdata[7:0] : in_tdata[15:8];
  assign pos      = xside ? in_tdata[39:16] : in_tdata[63:40];
  assign pos_o    = xside ? in_tdata[63:40] : in_tdata[39:16];
  assign dir      = xside ? dir_x : dir_y;
  assign dir_o    = xside ? dir_y : dir_x;
  assign neg      = xside ? in_tdata[100] : in_tdata[101];
  assign num_s = $signed({2'b0, wall_idx, 16'b0}) - $signed({2'b0, pos})
               + (neg ? 26'sd65536 : 26'sd0);
  assign anum  = num_s[25] ? 25'(-num_s) : num_s[24:0];
  assign adir  = dir[17] ? 18'(-dir) : dir;

  logic [24:0]        anum_r;
  logic [17:0]        adir_r;
  logic               sat_r;
  logic [15:0]        poso_r;
  logic signed [17:0] diro_r;
  logic               mir_r;

  always_ff @(posedge clk) begin
    if (en) begin
      anum_r <= anum;
      adir_r <= adir;
      sat_r  <= {1'b0, anum} >= {adir, 8'b0};
      poso_r <= pos_o[15:0];
      diro_r <= dir_o;
      mir_r  <= xside ? (dir_x > 18'sd0) : dir_y[17];
    end
  end

  // perpendicular distance divider
  logic [23:0] pq;
  logic [17:0] pr_unused;
  logic [35:0] side_d;

  rws_div #(.NW(41), .DW(18), .QW(24)) u_pdiv (
    .clk(clk), .en(en), .num({anum_r, 16'b0}), .den(adir_r), .quo(pq), .rem(pr_unused)
  );

  rws_dly #(.W(36), .N(24)) u_pside (
    .clk(clk), .en(en), .d({sat_r, poso_r, diro_r, mir_r}), .q(side_d)
  );

  logic [DW-1:0]      perp_r;
  logic [15:0]        poso_p_r;
  logic signed [17:0] diro_p_r;
  logic               mir_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      perp_r   <= side_d[35] ? rws_pkg::DIST_MAX : (pq | {24{pr_unused[0] & 1'b0}});
      poso_p_r <= side_d[34:19];
      diro_p_r <= side_d[18:1];
      mir_p_r  <= side_d[0];
    end
  end

  // line height divider
  logic [15:0] lq;
  logic [DW-1:0] lr_unused;
  logic lsat_d;
  logic [15:0] lh_r, lh_d;

  rws_div #(.NW(SW + 16), .DW(DW), .QW(16)) u_ldiv (
    .clk(clk), .en(en), .num((SW + 16)'(SCREEN_SIZE) << 16), .den(perp_r),
    .quo(lq), .rem(lr_unused)
  );

  rws_dly #(.W(1), .N(16)) u_lsat (
    .clk(clk), .en(en), .d(perp_r <= DW'(SCREEN_SIZE)), .q(lsat_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lh_r <= (lsat_d || (lr_unused != lr_unused)) ? 16'hFFFF : lq;
    end
  end

  rws_dly #(.W(16), .N(TW - 17)) u_lhd (
    .clk(clk), .en(en), .d(lh_r), .q(lh_d)
  );

  // row offset divider: |C*vs| / d
  logic [TW-1:0] rq;
  logic [DW-1:0] rr;
  logic [DW-1:0] perp_d;

  rws_div #(.NW(TW), .DW(DW), .QW(TW)) u_rdiv (
    .clk(clk), .en(en), .num(tabs_r),
    .den((perp_r == '0) ? DW'(1) : perp_r), .quo(rq), .rem(rr)
  );

  rws_dly #(.W(DW), .N(TW)) u_perpd (
    .clk(clk), .en(en), .d(perp_r), .q(perp_d)
  );

  // texture column
  logic signed [42:0] prod_full;
  logic [31:0]        prod_r, frac;
  logic [15:0]        poso_t_r;
  logic               mir_t_r, mir_u_r;
  logic [42:0]        twp;
  logic [10:0]        tcol_r;
  logic [11:0]        tmir;
  logic [9:0]         tex_r, tex_d;

  assign prod_full = $signed({1'b0, perp_r}) * diro_p_r;
  assign frac      = {poso_t_r, 16'b0} + prod_r;
  assign twp       = 43'(frac) * 43'(texw_r);
  assign tmir      = {1'b0, texw_r} - {1'b0, tcol_r} - 12'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_full[31:0];
      poso_t_r <= poso_p_r;
      mir_t_r  <= mir_p_r;
      tcol_r   <= twp[42:32];
      mir_u_r  <= mir_t_r;
      if (texw_r == '0) begin
        tex_r <= '0;
      end else if (mir_u_r) begin
        tex_r <= (tmir > 12'd1023) ? 10'd1023 : tmir[9:0];
      end else begin
        tex_r <= (tcol_r > 11'd1023) ? 10'd1023 : tcol_r[9:0];
      end
    end
  end

  rws_dly #(.W(10), .N(TW - 3)) u_texd (
    .clk(clk), .en(en), .d(tex_r), .q(tex_d)
  );

  // row values: trunc(a - t/d) from quotient and remainder
  logic signed [VW-1:0] a_s, a_e, qv, v_s, v_e, r_s, r_e;
  logic [15:0]          ds;
  logic signed [16:0]   de;

  always_comb begin
    a_s = VW'(C) - VW'(lh_d[15:1]);
    a_e = VW'(C) + VW'(lh_d[15:1]);
    qv  = $signed({3'b0, rq});
    v_s = tneg_r ? a_s + qv : a_s - qv;
    v_e = tneg_r ? a_e + qv : a_e - qv;
    r_s = v_s;
    r_e = v_e;
    if (rr != '0) begin
      if (!tneg_r && v_s > 0) r_s = v_s - VW'(1);
      if (tneg_r && v_s < 0)  r_s = v_s + VW'(1);
      if (!tneg_r && v_e > 0) r_e = v_e - VW'(1);
      if (tneg_r && v_e < 0)  r_e = v_e + VW'(1);
    end
    if (r_s < 0) ds = '0;
    else if (r_s > VW'(65535)) ds = 16'hFFFF;
    else ds = r_s[15:0];
    if (r_e >= VW'(SCREEN_SIZE)) de = 17'(SCREEN_SIZE - 1);
    else if (r_e < -VW'(65536)) de = 17'h10000;
    else de = r_e[16:0];
  end

  // output register
  logic [82:0] out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {tex_d, de, ds, lh_d, perp_d};
    end
  end

  assign out_tdata  = {5'b0, out_r};
  assign out_tvalid = vld_r[L-1];

  // checks
  a_de_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[72:56]) <= $signed(17'(SCREEN_SIZE - 1))))
    else $error("draw_end above last row");

  a_lh_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:0] <= 24'(SCREEN_SIZE)) |-> out_tdata[39:24] == 16'hFFFF)
    else $error("line height not saturated at short distance");

  a_tex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (texw_r == '0) |-> out_tdata[82:73] == '0)
    else $error("texture column nonzero with zero width");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while output stalled");

endmodule
